// ===== rtl/rfalu_pkg.sv =====
// Shared types and constants for the register file ALU.
package rfalu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  typedef enum logic [4:0] {
    CMD_READ  = 5'd0,
    CMD_CLEAR = 5'd1,
    CMD_INV   = 5'd2,
    CMD_NEG   = 5'd3,
    CMD_DEC   = 5'd4,
    CMD_INC   = 5'd5,
    CMD_MOVE  = 5'd6,
    CMD_NOT   = 5'd7,
    CMD_XCHG  = 5'd8,
    CMD_ADD   = 5'd9,
    CMD_SUB   = 5'd10,
    CMD_MUL   = 5'd11,
    CMD_DIV   = 5'd12,
    CMD_XOR   = 5'd13,
    CMD_MOD   = 5'd14,
    CMD_AND   = 5'd15,
    CMD_OR    = 5'd16,
    CMD_MAX   = 5'd17,
    CMD_MIN   = 5'd18
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_DIV0  = 2'd2
  } err_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic rd_second;
    logic exec;
    logic div_start;
    logic div_load;
    logic wr_xchg;
    logic wr_dst;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic use_div;
    logic xchg_wr;
    logic div_done;
  } dp_stat_t;

  // Unknown opcodes behave as read.
  function automatic cmd_e norm_cmd(logic [4:0] raw);
    cmd_e res;
    if (raw > CMD_MIN) begin
      res = CMD_READ;
    end else begin
      res = cmd_e'(raw);
    end
    return res;
  endfunction

endpackage

// ===== rtl/rfalu_ifs.sv =====
// Valid/ready channel interfaces for the command and result streams.
interface rfalu_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         command;
  logic [5:0]         dst_index;
  logic               src0_is_literal;
  logic [5:0]         src0_index;
  logic signed [31:0] src0_literal;
  logic               src1_is_literal;
  logic [5:0]         src1_index;
  logic signed [31:0] src1_literal;

  modport source (
    output valid, command, dst_index, src0_is_literal, src0_index, src0_literal,
           src1_is_literal, src1_index, src1_literal,
    input  ready
  );
  modport sink (
    input  valid, command, dst_index, src0_is_literal, src0_index, src0_literal,
           src1_is_literal, src1_index, src1_literal,
    output ready
  );
endinterface

interface rfalu_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         result_index;
  logic signed [31:0] result_value;
  logic [1:0]         error_code;

  modport source (
    output valid, result_index, result_value, error_code,
    input  ready
  );
  modport sink (
    input  valid, result_index, result_value, error_code,
    output ready
  );
endinterface

// ===== rtl/rfalu_div.sv =====
// Iterative signed divider, one quotient bit per cycle.
module rfalu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o
);

  localparam logic [rfalu_pkg::CNT_W-1:0] LAST = rfalu_pkg::CNT_W'(rfalu_pkg::DATA_W - 1);

  logic                        busy_q, done_q;
  logic [rfalu_pkg::CNT_W-1:0] cnt_q;
  logic [31:0]                 quo_q, rem_q, dvs_q;
  logic                        negq_q, negr_q;
  logic [32:0]                 rem_sh, diff;
  logic [31:0]                 dvd_abs, dvs_abs;

  assign dvd_abs = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
  assign dvs_abs = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
  assign rem_sh  = {rem_q, quo_q[31]};
  assign diff    = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dvd_abs;
      rem_q  <= '0;
      dvs_q  <= dvs_abs;
      negq_q <= dividend_i[31] ^ divisor_i[31];
      negr_q <= dividend_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = negq_q ? (32'd0 - quo_q) : quo_q;
  assign remainder_o = negr_q ? (32'd0 - rem_q) : rem_q;

endmodule

// ===== rtl/rfalu_ctrl.sv =====
// Sequencer for the register file ALU.
module rfalu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfalu_pkg::dp_cmd_t  cmd_o,
  input  rfalu_pkg::dp_stat_t stat_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_XCH  = 7'b0100000,
    S_WR   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RDA;
        end
      end
      S_RDA: begin
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_second = 1'b1;
        state_d         = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.use_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (stat_i.xchg_wr) begin
          state_d = S_XCH;
        end else begin
          state_d = S_WR;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_load = 1'b1;
          state_d        = S_WR;
        end
      end
      S_XCH: begin
        cmd_o.wr_xchg = 1'b1;
        state_d       = S_WR;
      end
      S_WR: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.wr_dst   = 1'b1;
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/rfalu_dp.sv =====
// Datapath: register file memory, operand fetch, ALU, divider and result register.
module rfalu_dp #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfalu_pkg::dp_cmd_t  cmd_i,
  output rfalu_pkg::dp_stat_t stat_o,
  input  logic [4:0]          command_i,
  input  logic [5:0]          dst_index_i,
  input  logic                src0_is_literal_i,
  input  logic [5:0]          src0_index_i,
  input  logic [31:0]         src0_literal_i,
  input  logic                src1_is_literal_i,
  input  logic [5:0]          src1_index_i,
  input  logic [31:0]         src1_literal_i,
  output logic [5:0]          result_index_o,
  output logic [31:0]         result_value_o,
  output logic [1:0]          error_code_o
);

  localparam int unsigned IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [6:0]  REG_LIMIT = 7'(REG_COUNT);

  // Captured item
  rfalu_pkg::cmd_e cmd_q;
  logic [5:0]      dst_q, s0_idx_q, s1_idx_q;
  logic            s0_lit_q, s1_lit_q;
  logic [31:0]     s0_val_q, s1_val_q;

  // Register file
  logic [31:0]          mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [IDX_W-1:0]     rd0_addr, rd1_addr, wr_addr;
  logic [31:0]          rd0_q, rd1_q, wr_data;
  logic                 rv0_q, rv1_q, wr_en;

  // Working values
  logic [31:0]          old_q, a_q, res_q;
  logic                 bad_a_q, wr_q;
  rfalu_pkg::err_e      err_q;
  logic                 dst_ok, s0_ok, s1_ok;
  logic [31:0]          old_val, a_val, b_val, val, mul_lo;
  logic                 a_bad, b_bad, bad, is_div, wr;

  // Result register
  logic [5:0]           out_idx_q;
  logic [31:0]          out_val_q;
  rfalu_pkg::err_e      out_err_q;

  // Divider
  logic                 div_done;
  logic [31:0]          div_quo, div_rem;

  assign dst_ok = {1'b0, dst_q} < REG_LIMIT;
  assign s0_ok  = {1'b0, s0_idx_q} < REG_LIMIT;
  assign s1_ok  = {1'b0, s1_idx_q} < REG_LIMIT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= rfalu_pkg::norm_cmd(command_i);
      dst_q    <= dst_index_i;
      s0_lit_q <= src0_is_literal_i;
      s0_idx_q <= src0_index_i;
      s0_val_q <= src0_literal_i;
      s1_lit_q <= src1_is_literal_i;
      s1_idx_q <= src1_index_i;
      s1_val_q <= src1_literal_i;
    end
  end

  // Memory ports
  assign rd0_addr = dst_q[IDX_W-1:0];
  assign rd1_addr = cmd_i.rd_second ? s1_idx_q[IDX_W-1:0] : s0_idx_q[IDX_W-1:0];
  assign wr_en    = cmd_i.wr_xchg || (cmd_i.wr_dst && wr_q && dst_ok);
  assign wr_addr  = cmd_i.wr_xchg ? s0_idx_q[IDX_W-1:0] : dst_q[IDX_W-1:0];
  assign wr_data  = cmd_i.wr_xchg ? old_q : res_q;

  always_ff @(posedge clk_i) begin
    rd0_q <= mem_q[rd0_addr];
    rd1_q <= mem_q[rd1_addr];
    rv0_q <= valid_q[rd0_addr];
    rv1_q <= valid_q[rd1_addr];
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec && cmd_q == rfalu_pkg::CMD_CLEAR) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // Operand fetch
  assign old_val = (dst_ok && rv0_q) ? rd0_q : 32'd0;
  assign a_bad   = !s0_lit_q && !s0_ok;
  assign a_val   = s0_lit_q ? s0_val_q : ((s0_ok && rv1_q) ? rd1_q : 32'd0);
  assign b_bad   = !s1_lit_q && !s1_ok;
  assign b_val   = s1_lit_q ? s1_val_q : ((s1_ok && rv1_q) ? rd1_q : 32'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_second) begin
      old_q   <= old_val;
      a_q     <= a_val;
      bad_a_q <= a_bad;
    end
  end

  // ALU
  assign mul_lo = a_q * b_val;
  assign is_div = (cmd_q == rfalu_pkg::CMD_DIV) || (cmd_q == rfalu_pkg::CMD_MOD);
  assign bad    = ((cmd_q >= rfalu_pkg::CMD_MOVE) && bad_a_q) ||
                  ((cmd_q >= rfalu_pkg::CMD_ADD) && b_bad);

  always_comb begin
    val = old_q;
    wr  = 1'b1;
    unique case (cmd_q)
      rfalu_pkg::CMD_INV:  val = ~old_q;
      rfalu_pkg::CMD_NEG:  val = 32'd0 - old_q;
      rfalu_pkg::CMD_DEC:  val = old_q - 32'd1;
      rfalu_pkg::CMD_INC:  val = old_q + 32'd1;
      rfalu_pkg::CMD_MOVE: val = a_q;
      rfalu_pkg::CMD_NOT:  val = ~a_q;
      rfalu_pkg::CMD_XCHG: val = a_q;
      rfalu_pkg::CMD_ADD:  val = a_q + b_val;
      rfalu_pkg::CMD_SUB:  val = a_q - b_val;
      rfalu_pkg::CMD_MUL:  val = mul_lo;
      rfalu_pkg::CMD_DIV,
      rfalu_pkg::CMD_MOD:  wr = (b_val != 32'd0);
      rfalu_pkg::CMD_XOR:  val = a_q ^ b_val;
      rfalu_pkg::CMD_AND:  val = a_q & b_val;
      rfalu_pkg::CMD_OR:   val = a_q | b_val;
      rfalu_pkg::CMD_MAX:  val = ($signed(a_q) > $signed(b_val)) ? a_q : b_val;
      rfalu_pkg::CMD_MIN:  val = ($signed(a_q) < $signed(b_val)) ? a_q : b_val;
      default:             wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= val;
      wr_q  <= wr;
      if (bad) begin
        err_q <= rfalu_pkg::ERR_INDEX;
      end else if (is_div && b_val == 32'd0) begin
        err_q <= rfalu_pkg::ERR_DIV0;
      end else begin
        err_q <= rfalu_pkg::ERR_OK;
      end
    end else if (cmd_i.div_load) begin
      res_q <= (cmd_q == rfalu_pkg::CMD_DIV) ? div_quo : div_rem;
    end
  end

  rfalu_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (a_q),
    .divisor_i   (b_val),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign stat_o.use_div  = is_div && (b_val != 32'd0);
  assign stat_o.xchg_wr  = (cmd_q == rfalu_pkg::CMD_XCHG) && !s0_lit_q && s0_ok && dst_ok;
  assign stat_o.div_done = div_done;

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q <= dst_q;
      if (cmd_q == rfalu_pkg::CMD_CLEAR) begin
        out_val_q <= '0;
        out_err_q <= rfalu_pkg::ERR_OK;
      end else if (!dst_ok) begin
        out_val_q <= '0;
        out_err_q <= rfalu_pkg::ERR_INDEX;
      end else begin
        out_val_q <= wr_q ? res_q : old_q;
        out_err_q <= err_q;
      end
    end
  end

  assign result_index_o = out_idx_q;
  assign result_value_o = out_val_q;
  assign error_code_o   = out_err_q;

endmodule

// ===== rtl/register_file_alu_top.sv =====
// Register file ALU top level: sequencer, datapath and result channel.
// Each item passes read, second read, execute, an exchange write for a register
// exchange or the 32-step serial divider for nonzero div and mod, and result write.
// One item in flight; input is ready again once the result is registered.
// Reset clears control state and marks every register as zero at once.
module register_file_alu_top #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfalu_in_if.sink    in_i,
  rfalu_out_if.source out_o
);

  rfalu_pkg::dp_cmd_t  dp_cmd;
  rfalu_pkg::dp_stat_t dp_stat;

  rfalu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  rfalu_dp #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .command_i         (in_i.command),
    .dst_index_i       (in_i.dst_index),
    .src0_is_literal_i (in_i.src0_is_literal),
    .src0_index_i      (in_i.src0_index),
    .src0_literal_i    (in_i.src0_literal),
    .src1_is_literal_i (in_i.src1_is_literal),
    .src1_index_i      (in_i.src1_index),
    .src1_literal_i    (in_i.src1_literal),
    .result_index_o    (out_o.result_index),
    .result_value_o    (out_o.result_value),
    .error_code_o      (out_o.error_code)
  );

`ifndef NO_ASSERTIONS
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.error_code != 2'd3))
    else $error("undefined error code on result");

  a_bad_dst_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ({1'b0, out_o.result_index} >= 7'(REG_COUNT)))
      |-> (out_o.result_value == 32'sd0))
    else $error("out-of-range destination returned nonzero value");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !$rose(out_o.valid))
    else $error("result appeared one cycle after transfer");

  a_dp_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.load, dp_cmd.exec, dp_cmd.div_load, dp_cmd.wr_xchg, dp_cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule
